@@ rtl/core/rits_pkg.sv @@
// shared constants, types and the symbol lookup for the radix text converter
// no dependencies
package rits_pkg;

  localparam int MAX_RADIX_DEF  = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int TABLE_IDX_W = 4;   // symbol table holds sixteen bytes
  localparam int SYM_W       = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int RADIX_LEN_W = 5;

  localparam logic [SYM_W-1:0] SIGN_BYTE = 8'h2D;
  localparam logic [SYM_W-1:0] PLUS_BYTE = 8'h2B;
  localparam logic [SYM_W-1:0] NUL_BYTE  = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

  // byte of the symbol table for one digit value
  function automatic logic [SYM_W-1:0] sym_at(input logic [CFG_W-1:0] lo,
                                              input logic [CFG_W-1:0] hi,
                                              input logic [TABLE_IDX_W-1:0] idx);
    logic [CFG_W-1:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: SYM_W];
  endfunction

endpackage

@@ rtl/core/radix_integer_to_symbols.sv @@
// top level of the radix text converter: config registers, sequencer, output register
// depends on rits_pkg, rits_divider, rits_table_check, rits_digit_stack
//
// Converts one signed VALUE_BITS-bit integer per input transaction into text in the
// radix set by radix_length, one byte per output transaction, most significant digit
// first, with a leading '-' for negative values and last set on the final byte. An
// invalid symbol table (radix below 2 or above MAX_RADIX, a zero, '+' or '-' among the
// used symbols, or a repeated symbol) yields no output at all. One item is in work at
// a time and in_ready stays low until its final byte is loaded into the output
// register. Per item the block accepts the value, runs the table check, then divides
// once per digit in the shared serial divider, loads a '-' byte for a negative value,
// then reads each digit back through the digit stack read port; the '-' and digit
// bytes each wait for a free output slot, so any stall on out_ready holds them.
module radix_integer_to_symbols #(
  parameter int MAX_RADIX  = rits_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = rits_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [rits_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rits_pkg::CFG_W-1:0]       cfg_wdata,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [VALUE_BITS-1:0]     in_value,
  // output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rits_pkg::SYM_W-1:0]       out_text_byte,
  output logic                             out_last
);
  import rits_pkg::*;

  localparam int DIGIT_W = $clog2(MAX_RADIX);
  localparam int ADDR_W  = $clog2(VALUE_BITS);
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SIGN  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  // configuration registers
  logic [RADIX_LEN_W-1:0] radix_length_r;
  logic [CFG_W-1:0]       symbols_low_r;
  logic [CFG_W-1:0]       symbols_high_r;

  // sequencer
  state_t                 state_r, state_nxt;
  logic [VALUE_BITS-1:0]  mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]       out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  // unit hookups
  logic                   chk_start;
  chk_status_t            chk_st;
  logic                   div_start;
  logic [VALUE_BITS-1:0]  div_dividend;
  logic                   div_done;
  logic [VALUE_BITS-1:0]  div_quot;
  logic [DIGIT_W-1:0]     div_rem;
  logic                   stk_rd_en;
  logic [DIGIT_W-1:0]     stk_rd_data;
  logic [CNT_W-1:0]       cnt_m1;

  logic                   in_fire;
  logic                   slot_free;
  logic [VALUE_BITS-1:0]  value_u;

  assign in_ready  = state_r == ST_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign value_u   = in_value;
  assign cnt_m1    = cnt_r - 1'b1;

  // config writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_length_r <= '0;
      symbols_low_r  <= '0;
      symbols_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX_LENGTH: radix_length_r <= cfg_wdata[RADIX_LEN_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low_r  <= cfg_wdata;
        REG_SYMBOLS_HIGH: symbols_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // table check kicks off with each accepted transaction
  assign chk_start = in_fire;

  rits_table_check #(
    .MAX_RADIX (MAX_RADIX)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (chk_start),
    .radix_length (radix_length_r),
    .symbols_low  (symbols_low_r),
    .symbols_high (symbols_high_r),
    .status       (chk_st)
  );

  // first division takes the magnitude, later ones chain on the quotient
  assign div_dividend = (state_r == ST_DIV) ? div_quot : mag_r;
  assign div_start    = ((state_r == ST_CHECK) && chk_st.done && chk_st.ok) ||
                        ((state_r == ST_DIV) && div_done && (div_quot != '0));

  rits_divider #(
    .VALUE_BITS (VALUE_BITS),
    .DIGIT_W    (DIGIT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   ((DIGIT_W + 1)'(radix_length_r)),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // digits land least significant first and are read back from the top down
  assign stk_rd_en = state_r == ST_READ;

  rits_digit_stack #(
    .DEPTH   (VALUE_BITS),
    .DIGIT_W (DIGIT_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   ((state_r == ST_DIV) && div_done),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (div_rem),
    .rd_en   (stk_rd_en),
    .rd_addr (cnt_m1[ADDR_W-1:0]),
    .rd_data (stk_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // magnitude without overflow, most negative value included
          neg_nxt   = value_u[VALUE_BITS-1];
          mag_nxt   = value_u[VALUE_BITS-1] ? (~value_u + 1'b1) : value_u;
          cnt_nxt   = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_st.done) begin
          state_nxt = chk_st.ok ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          cnt_nxt = cnt_r + 1'b1;
          if (div_quot == '0) begin
            state_nxt = neg_r ? ST_SIGN : ST_READ;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = SIGN_BYTE;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = sym_at(symbols_low_r, symbols_high_r, TABLE_IDX_W'(stk_rd_data));
          out_last_nxt  = cnt_r == CNT_W'(1);
          cnt_nxt       = cnt_m1;
          state_nxt     = (cnt_r == CNT_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_byte = out_byte_r;
  assign out_last      = out_last_r;

  // an accepted transaction keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted while previous item still in work");

  // divider results only arrive while the sequencer waits for them
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the division phase");

  // digit count stays within the stack depth
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VALUE_BITS))
    else $error("digit count beyond stack depth");

  // output register is only loaded while the slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_text_byte) && $stable(out_last)))
    else $error("pending output byte overwritten");

endmodule

@@ rtl/core/rits_divider.sv @@
// restoring divider, one quotient bit per cycle
// depends on rits_pkg
module rits_divider #(
  parameter int VALUE_BITS = rits_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_W    = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIGIT_W:0]      divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIGIT_W-1:0]    remainder
);
  import rits_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] quot_r, quot_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [DIGIT_W:0]      trial;
  logic [DIGIT_W:0]      diff;
  logic                  ge;

  assign trial = {rem_r, quot_r[VALUE_BITS-1]};
  assign ge    = trial >= divisor;
  assign diff  = trial - divisor;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      quot_nxt = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[VALUE_BITS-2:0], ge};
      rem_nxt  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quot_r;
  assign remainder = rem_r;

endmodule

@@ rtl/core/rits_table_check.sv @@
// symbol table check: one comparator walks all symbol pairs
// depends on rits_pkg
module rits_table_check #(
  parameter int MAX_RADIX = rits_pkg::MAX_RADIX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rits_pkg::RADIX_LEN_W-1:0]    radix_length,
  input  logic [rits_pkg::CFG_W-1:0]          symbols_low,
  input  logic [rits_pkg::CFG_W-1:0]          symbols_high,
  output rits_pkg::chk_status_t               status
);
  import rits_pkg::*;

  logic                   run_r, run_nxt;
  logic [TABLE_IDX_W-1:0] i_r, i_nxt;
  logic [TABLE_IDX_W-1:0] j_r, j_nxt;
  chk_status_t            st_r, st_nxt;
  logic [TABLE_IDX_W-1:0] last_idx;
  logic [SYM_W-1:0]       sym_a;
  logic [SYM_W-1:0]       sym_b;
  logic                   bad;

  assign last_idx = TABLE_IDX_W'(radix_length - 1'b1);
  assign sym_a    = sym_at(symbols_low, symbols_high, i_r);
  assign sym_b    = sym_at(symbols_low, symbols_high, j_r);

  // diagonal entry checks the symbol itself, others check for a repeat
  always_comb begin
    if (i_r == j_r) begin
      bad = (sym_a == NUL_BYTE) || (sym_a == SIGN_BYTE) || (sym_a == PLUS_BYTE);
    end else begin
      bad = sym_a == sym_b;
    end
  end

  always_comb begin
    run_nxt = run_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    st_nxt  = '{done: 1'b0, ok: st_r.ok};
    if (start) begin
      i_nxt = '0;
      j_nxt = '0;
      if (radix_length < RADIX_LEN_W'(2) || radix_length > RADIX_LEN_W'(MAX_RADIX)) begin
        st_nxt = '{done: 1'b1, ok: 1'b0};
      end else begin
        run_nxt = 1'b1;
      end
    end else if (run_r) begin
      if (bad) begin
        run_nxt = 1'b0;
        st_nxt  = '{done: 1'b1, ok: 1'b0};
      end else if (j_r == last_idx) begin
        if (i_r == last_idx) begin
          run_nxt = 1'b0;
          st_nxt  = '{done: 1'b1, ok: 1'b1};
        end else begin
          i_nxt = i_r + 1'b1;
          j_nxt = i_r + 1'b1;
        end
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      st_r  <= '0;
    end else begin
      run_r <= run_nxt;
      st_r  <= st_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
  end

  assign status = st_r;

endmodule

@@ rtl/core/rits_digit_stack.sv @@
// digit store, one write and one registered read per cycle
// depends on rits_pkg
module rits_digit_stack #(
  parameter int DEPTH   = rits_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_W = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DIGIT_W-1:0]       wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DIGIT_W-1:0]       rd_data
);
  import rits_pkg::*;

  logic [DIGIT_W-1:0] mem_r [DEPTH];
  logic [DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ dv/radix_text_checker.sv @@
// checker for the radix text converter: tracks config writes, predicts text bytes, compares them
// depends on rits_pkg; hands the mismatch count and the number of bytes still due to the top
module radix_text_checker #(
  parameter int MAX_RADIX  = rits_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = rits_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rits_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rits_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [VALUE_BITS-1:0]   in_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [rits_pkg::SYM_W-1:0]     out_text_byte,
  input  logic                           out_last,
  output int                             text_mismatches,
  output int                             text_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rits_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] text_byte;
    logic             last;
  } text_char_t;

  logic [RADIX_LEN_W-1:0] radix_len;
  logic [CFG_W-1:0]       sym_lo;
  logic [CFG_W-1:0]       sym_hi;
  text_char_t             pending_text[$];
  int                     errors;

  function automatic logic [SYM_W-1:0] symbol_for(input int digit);
    logic [2*CFG_W-1:0] sym_bits;
    sym_bits = {sym_hi, sym_lo};
    return sym_bits[digit*SYM_W +: SYM_W];
  endfunction

  function automatic bit table_usable();
    int               n;
    logic [SYM_W-1:0] s;
    n = int'(radix_len);
    if (n < 2 || n > MAX_RADIX) return 1'b0;
    for (int i = 0; i < n; i++) begin
      s = symbol_for(i);
      if (s == NUL_BYTE || s == SIGN_BYTE || s == PLUS_BYTE) return 1'b0;
      for (int j = i + 1; j < n; j++)
        if (symbol_for(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the text of one value, most significant digit first
  task automatic spell_value(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] base;
    int                    digit [VALUE_BITS+1];
    int                    count;
    if (!table_usable()) return;
    base  = VALUE_BITS'(radix_len);
    mag   = value[VALUE_BITS-1] ? -value : value;
    count = 0;
    do begin
      digit[count] = int'(mag % base);
      mag = mag / base;
      count++;
    end while (mag != 0);
    if (value[VALUE_BITS-1]) pending_text.push_back(text_char_t'{SIGN_BYTE, 1'b0});
    for (int k = count - 1; k >= 0; k--)
      pending_text.push_back(text_char_t'{symbol_for(digit[k]), k == 0});
  endtask

  always @(posedge clk) begin : watch
    text_char_t want;
    if (!rst_n) begin
      radix_len = '0;
      sym_lo    = '0;
      sym_hi    = '0;
      errors    = 0;
      pending_text.delete();
      text_mismatches <= 0;
      text_pending    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIX_LENGTH: radix_len = cfg_wdata[RADIX_LEN_W-1:0];
          REG_SYMBOLS_LOW:  sym_lo = cfg_wdata;
          REG_SYMBOLS_HIGH: sym_hi = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_text.size() == 0) begin
          $error("unexpected text byte %h, last %b", out_text_byte, out_last);
          errors++;
        end else begin
          want = pending_text.pop_front();
          if (out_text_byte !== want.text_byte) begin
            $error("text_byte: expected %h, got %h", want.text_byte, out_text_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) spell_value(in_value);
      text_pending    <= pending_text.size();
      text_mismatches <= errors;
    end
  end

endmodule

@@ dv/tb_radix_integer_to_symbols.sv @@
// top of the radix text converter testbench: clock, reset, config writes, stimulus, verdict
// depends on rits_pkg, radix_integer_to_symbols and radix_text_checker
module tb_radix_integer_to_symbols;
  timeunit 1ns;
  timeprecision 1ps;

  import rits_pkg::*;

  // index 3 is not mapped to any register, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int RANDOM_ITEMS   = 108;
  localparam int LONG_HOLD      = 2500;   // receiver hold-off, longer than one radix 2 item
  localparam int DRAIN_CYCLES   = 1500;   // long enough for the worst item, the most negative value at radix 2
  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no transaction of any kind

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]              cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [VALUE_BITS_DEF-1:0] in_value;
  logic                          out_valid;
  logic                          out_ready;
  logic [SYM_W-1:0]              out_text_byte;
  logic                          out_last;
  int                            text_mismatches;
  int                            text_pending;
  bit                            send_steady;   // sender skips its gaps in this phase
  bit                            hold_request;  // asks the receiver for one long hold-off

  radix_integer_to_symbols dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_byte (out_text_byte),
    .out_last      (out_last)
  );

  radix_text_checker text_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_text_byte   (out_text_byte),
    .out_last        (out_last),
    .text_mismatches (text_mismatches),
    .text_pending    (text_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // symbol string to {symbols_high, symbols_low}, first character is digit 0
  function automatic logic [2*CFG_W-1:0] pack_symbols(input string s);
    logic [2*CFG_W-1:0] bits;
    bits = '0;
    for (int i = 0; i < s.len() && i < 16; i++) bits[i*SYM_W +: SYM_W] = s[i];
    return bits;
  endfunction

  // value mix: raw random, small, extremes, near powers of the radix, short bit patterns
  function automatic logic [31:0] pick_value(input int radix);
    longint p;
    int     k;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        p = longint'($urandom_range(0, 40));
        return $urandom_range(0, 1) ? 32'(-p) : 32'(p);
      end
      3: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      4: begin
        p = 1;
        k = $urandom_range(1, 31);
        repeat (k) if (p * radix <= 64'sh8000_0000) p = p * radix;
        p = p + longint'($urandom_range(0, 2)) - 1;
        return $urandom_range(0, 1) ? 32'(-p) : 32'(p);
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // one input transaction, entered and left at a falling edge
  task automatic offer(input logic [31:0] value);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // stop sending, wait for all due text, then give a dropped item time to finish
  task automatic settle();
    in_valid <= 1'b0;
    while (text_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // back to back register writes, plus one to the unmapped index
  task automatic load_table(input logic [CFG_W-1:0] len_word, input logic [2*CFG_W-1:0] bits);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RADIX_LENGTH;
    cfg_wdata <= len_word;
    @(negedge clk);
    cfg_index <= REG_SYMBOLS_LOW;
    cfg_wdata <= bits[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_SYMBOLS_HIGH;
    cfg_wdata <= bits[2*CFG_W-1:CFG_W];
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_wdata <= {$urandom, $urandom};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // a broken table must swallow the item without any text
  task automatic expect_silence(input logic [CFG_W-1:0] len_word,
                                input logic [2*CFG_W-1:0] bits);
    load_table(len_word, bits);
    offer($urandom);
    settle();
  endtask

  // random table, mostly well formed with distinct legal bytes; unused bytes are pure noise
  task automatic random_table(input bit broken, output int radix);
    logic [2*CFG_W-1:0] bits;
    logic [CFG_W-1:0]   len_word;
    logic [SYM_W-1:0]   s;
    int                 n;
    int                 pos;
    int                 other;
    bit                 clash;
    case ($urandom_range(0, 3))
      0:       n = 2;
      1:       n = 16;
      default: n = $urandom_range(2, 16);
    endcase
    bits = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      do begin
        s = SYM_W'($urandom_range(1, 255));
        clash = (s == PLUS_BYTE || s == SIGN_BYTE);
        for (int j = 0; j < i; j++) if (bits[j*SYM_W +: SYM_W] == s) clash = 1'b1;
      end while (clash);
      bits[i*SYM_W +: SYM_W] = s;
    end
    // junk above the 5-bit radix field must be dropped
    len_word = {$urandom, $urandom};
    len_word[RADIX_LEN_W-1:0] = RADIX_LEN_W'(n);
    if (broken) begin
      pos = $urandom_range(0, n - 1);
      case ($urandom_range(0, 4))
        0: begin
          n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
          len_word[RADIX_LEN_W-1:0] = RADIX_LEN_W'(n);
        end
        1: bits[pos*SYM_W +: SYM_W] = PLUS_BYTE;
        2: bits[pos*SYM_W +: SYM_W] = SIGN_BYTE;
        3: bits[pos*SYM_W +: SYM_W] = NUL_BYTE;
        default: begin
          pos   = $urandom_range(1, n - 1);
          other = $urandom_range(0, pos - 1);
          bits[pos*SYM_W +: SYM_W] = bits[other*SYM_W +: SYM_W];
        end
      endcase
    end
    load_table(len_word, bits);
    radix = n;
  endtask

  // sender: directed items first, then random tables with random values
  initial begin : stimulus
    logic [31:0]        dec_values [8] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                           32'h8000_0000, 32'd10, -32'sd10, 32'd12345};
    logic [2*CFG_W-1:0] bits;
    int                 radix;
    int                 sent;
    int                 phase;
    int                 count;
    bit                 broken;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_RADIX_LENGTH;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_value     = '0;
    send_steady  = 1'b0;
    hold_request = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers come out of reset as zero, so a radix of zero drops this item
    offer(32'd123);
    settle();

    // decimal: zero, one, minus one, both extremes, sign around a carry
    load_table(64'd10, pack_symbols("0123456789"));
    foreach (dec_values[i]) offer(dec_values[i]);
    settle();

    // full table, both symbol words in use
    load_table(64'd16, pack_symbols("0123456789ABCDEF"));
    offer(32'h7FFF_FFFF);
    offer(32'h8000_0000);
    offer(32'hDEAD_BEEF);
    settle();

    // binary with the extreme symbol bytes; most negative value gives the longest text
    load_table(64'd2, {112'd0, 8'h01, 8'hFF});
    offer(32'h8000_0000);
    offer(32'd5);
    settle();

    // radix 3 from a word with junk above the field; '-' and zero bytes past the used ones
    bits = pack_symbols("xyz");
    bits[3*SYM_W +: SYM_W] = SIGN_BYTE;
    bits[4*SYM_W +: SYM_W] = NUL_BYTE;
    load_table(64'hFFFF_FFFF_FFFF_FFE3, bits);
    offer(-32'sd7);
    offer(32'd100);
    settle();

    // broken tables: radix one, radix above the maximum, '+', '-', zero byte, repeat
    expect_silence(64'd1, pack_symbols("01"));
    expect_silence(64'd17, pack_symbols("0123456789ABCDEF"));
    bits = pack_symbols("0123456789ABCDEF");
    bits[15*SYM_W +: SYM_W] = PLUS_BYTE;
    expect_silence(64'd16, bits);
    expect_silence(64'd10, pack_symbols("-123456789"));
    expect_silence(64'd5, pack_symbols("0123"));
    expect_silence(64'd12, pack_symbols("0123456789A0"));

    // random phases; each ends with a pause until all text is in
    sent  = 0;
    phase = 0;
    hold_request = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      broken = (phase != 0) && ($urandom_range(0, 5) == 0);
      send_steady = (phase % 3 == 2);
      random_table(broken, radix);
      count = broken ? 3 : $urandom_range(8, 16);
      repeat (count) offer(pick_value(radix));
      if (!broken) sent += count;
      settle();
      phase++;
    end

    if (text_mismatches == 0 && text_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: random gaps after each output transaction, steady stretches now and then,
  // and one long hold-off so the block stalls with the next item waiting at its input
  initial begin : text_sink
    int gap;
    bit steady;
    bit hold_served;
    out_ready   = 1'b0;
    steady      = 1'b0;
    hold_served = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    out_ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
      if ($urandom_range(0, 19) == 0) steady = !steady;
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        gap = LONG_HOLD;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 5);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any transaction or register write
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rits_pkg.sv
rtl/core/rits_divider.sv
rtl/core/rits_table_check.sv
rtl/core/rits_digit_stack.sv
rtl/core/radix_integer_to_symbols.sv
dv/radix_text_checker.sv
dv/tb_radix_integer_to_symbols.sv
